// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, reset on rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/fngm_pkg.sv -----
// ----------------------------------------------------------------------------
// fngm_pkg
// Shared constants for the four-neighbor geometric mean stencil.
// ----------------------------------------------------------------------------
`default_nettype none
package fngm_pkg;
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int SAMPLE_W = 16;
  localparam int ROW_W    = 16;
  localparam int COL_W    = 10;
  localparam int FW_REG_W = 11;
  localparam int FH_REG_W = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [FW_REG_W-1:0] FRAME_WIDTH_RST  = FW_REG_W'(1024);
  localparam logic [FH_REG_W-1:0] FRAME_HEIGHT_RST = FH_REG_W'(1024);

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;
endpackage
`default_nettype wire

// ----- sv/fngm_ram.sv -----
// ----------------------------------------------------------------------------
// fngm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module fngm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- sv/fngm_front.sv -----
// ----------------------------------------------------------------------------
// fngm_front
// Accepts samples, tracks raster position, reads the neighbor window from the
// two row banks and hands one job word per sample to the queue.
// ----------------------------------------------------------------------------
`default_nettype none
module fngm_front #(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 16,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int JW = 5 * SAMPLE_BITS + 16 + CW + 4
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic signed [fngm_pkg::SAMPLE_W-1:0] in_sample,
  input  wire logic [fngm_pkg::FW_REG_W-1:0]  frame_width,
  input  wire logic [fngm_pkg::FH_REG_W-1:0]  frame_height,
  output logic                                q_push,
  output logic [JW-1:0]                       q_data,
  input  wire logic                           q_full
);
  import fngm_pkg::*;

  localparam int SB   = SAMPLE_BITS;
  localparam int AW   = CW + 1;
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (WW > FW_REG_W) ? WW : FW_REG_W;

  typedef struct packed {
    logic signed [SB-1:0] up;
    logic signed [SB-1:0] down;
    logic signed [SB-1:0] left;
    logic signed [SB-1:0] right;
    logic signed [SB-1:0] center;
    logic [ROW_W-1:0]     row;
    logic [CW-1:0]        col;
    logic                 has_prev;
    logic                 interior;
    logic                 last_row;
    logic                 last_col;
  } job_t;

  typedef enum logic [1:0] {S_IDLE, S_RD2, S_CAP, S_PUSH} state_t;

  state_t             state_r, state_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [CW-1:0]      col_r, col_nxt;
  job_t               job_r, job_nxt;

  logic [CMPW-1:0]    wide_w;
  logic [WW-1:0]      w_eff;
  logic [CW-1:0]      last_idx;
  logic [CW-1:0]      c_eff;
  logic [ROW_W-1:0]   h_eff;
  logic [ROW_W-1:0]   r_prev;
  logic               last_row, last_col, interior;
  logic signed [SB-1:0] s_ext;
  logic               accept;

  logic [AW-1:0]      raddr0, raddr1;
  logic [SB-1:0]      rdata0, rdata1;
  logic               ram_we;
  logic [AW-1:0]      waddr;

  assign wide_w = CMPW'(frame_width);

  always_comb begin
    priority if (wide_w == '0) begin
      w_eff = WW'(1);
    end else if (wide_w > CMPW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(wide_w);
    end
  end

  assign last_idx = CW'(w_eff - WW'(1));
  assign c_eff    = (WW'(col_r) >= w_eff) ? last_idx : col_r;
  assign h_eff    = (frame_height < ROW_W'(2)) ? ROW_W'(2) : frame_height;
  assign r_prev   = row_r - ROW_W'(1);
  assign last_row = row_r >= (h_eff - ROW_W'(1));
  assign last_col = c_eff == last_idx;
  assign interior = (row_r != '0) && (r_prev != '0) && (r_prev < (h_eff - ROW_W'(1)))
                    && (c_eff != '0) && (c_eff < last_idx);
  assign s_ext    = in_sample[SB-1:0];

  assign in_ready = state_r == S_IDLE;
  assign accept   = in_valid && in_ready;
  assign q_push   = (state_r == S_PUSH) && !q_full;
  assign q_data   = job_r;

  // read up and center at accept, left and right in S_RD2
  always_comb begin
    if (state_r == S_RD2) begin
      raddr0 = {~job_r.row[0], job_r.col - CW'(1)};
      raddr1 = {~job_r.row[0], job_r.col + CW'(1)};
    end else begin
      raddr0 = {row_r[0], c_eff};
      raddr1 = {~row_r[0], c_eff};
    end
  end

  assign ram_we = state_r == S_RD2;
  assign waddr  = {job_r.row[0], job_r.col};

  fngm_ram #(.WIDTH(SB), .DEPTH(2 << CW)) u_ram0 (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (job_r.down),
    .raddr (raddr0),
    .rdata (rdata0)
  );

  fngm_ram #(.WIDTH(SB), .DEPTH(2 << CW)) u_ram1 (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (job_r.down),
    .raddr (raddr1),
    .rdata (rdata1)
  );

  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    job_nxt   = job_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          job_nxt.down     = s_ext;
          job_nxt.row      = row_r;
          job_nxt.col      = c_eff;
          job_nxt.has_prev = row_r != '0;
          job_nxt.interior = interior;
          job_nxt.last_row = last_row;
          job_nxt.last_col = last_col;
          if (last_col) begin
            col_nxt = '0;
            row_nxt = last_row ? '0 : row_r + ROW_W'(1);
          end else begin
            col_nxt = c_eff + CW'(1);
          end
          state_nxt = S_RD2;
        end
      end
      S_RD2: begin
        job_nxt.up     = rdata0;
        job_nxt.center = rdata1;
        state_nxt      = S_CAP;
      end
      S_CAP: begin
        job_nxt.left  = rdata0;
        job_nxt.right = rdata1;
        state_nxt     = S_PUSH;
      end
      S_PUSH: begin
        if (!q_full) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      row_r   <= '0;
      col_r   <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
    end
    job_r <= job_nxt;
  end
endmodule
`default_nettype wire

// ----- sv/fngm_queue.sv -----
// ----------------------------------------------------------------------------
// fngm_queue
// Short register FIFO between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none
module fngm_queue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNTW = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  empty
);
  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = cnt_r == CNTW'(DEPTH);
  assign empty    = cnt_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNTW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      slot_r[wp_r] <= push_data;
    end
  end
endmodule
`default_nettype wire

// ----- sv/fngm_back.sv -----
// ----------------------------------------------------------------------------
// fngm_back
// Takes job words, computes the floor fourth root of the neighbor product
// with a shared bit-serial square root run twice, and emits result words.
// ----------------------------------------------------------------------------
`default_nettype none
module fngm_back #(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 16,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int JW = 5 * SAMPLE_BITS + 16 + CW + 4
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [JW-1:0]                     q_data,
  input  wire logic                              q_empty,
  output logic                                   q_pop,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [fngm_pkg::SAMPLE_W-1:0]   out_value,
  output logic [fngm_pkg::ROW_W-1:0]             out_row,
  output logic [fngm_pkg::COL_W-1:0]             out_col,
  output logic                                   out_frame_done
);
  import fngm_pkg::*;

  localparam int SB   = SAMPLE_BITS;
  localparam int PW   = 4 * SB;
  localparam int RW   = 2 * SB;
  localparam int RMW  = RW + 3;
  localparam int NW   = $clog2(RW);
  localparam logic signed [SB-1:0] MAXV = {1'b0, {(SB-1){1'b1}}};

  typedef struct packed {
    logic signed [SB-1:0] up;
    logic signed [SB-1:0] down;
    logic signed [SB-1:0] left;
    logic signed [SB-1:0] right;
    logic signed [SB-1:0] center;
    logic [ROW_W-1:0]     row;
    logic [CW-1:0]        col;
    logic                 has_prev;
    logic                 interior;
    logic                 last_row;
    logic                 last_col;
  } job_t;

  typedef enum logic [2:0] {B_IDLE, B_MUL1, B_MUL2, B_ROOT, B_EMIT1, B_EMIT2} state_t;

  state_t               state_r, state_nxt;
  job_t                 job_r, job_nxt, job_in;
  logic signed [SB-1:0] val_r, val_nxt;
  logic [RW-1:0]        pab_r, pab_nxt, pcd_r, pcd_nxt;
  logic [PW-1:0]        x_r, x_nxt;
  logic [RMW-1:0]       rem_r, rem_nxt;
  logic [RW-1:0]        root_r, root_nxt;
  logic [NW-1:0]        cnt_r, cnt_nxt;
  logic                 pass_r, pass_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic signed [SB-1:0] out_val_r, out_val_nxt;
  logic [ROW_W-1:0]     out_row_r, out_row_nxt;
  logic [CW-1:0]        out_col_r, out_col_nxt;
  logic                 out_done_r, out_done_nxt;

  logic [SB-1:0]        mag_u, mag_d, mag_l, mag_r;
  logic                 any_zero, odd_neg, slot_free;
  logic [RMW-1:0]       rem_sh, trial, rem_step;
  logic [RW-1:0]        root_step;

  assign job_in   = q_data;
  assign any_zero = (job_in.up == '0) || (job_in.down == '0)
                    || (job_in.left == '0) || (job_in.right == '0);
  assign odd_neg  = job_in.up[SB-1] ^ job_in.down[SB-1]
                    ^ job_in.left[SB-1] ^ job_in.right[SB-1];

  assign mag_u = job_r.up[SB-1]    ? SB'(-job_r.up)    : SB'(job_r.up);
  assign mag_d = job_r.down[SB-1]  ? SB'(-job_r.down)  : SB'(job_r.down);
  assign mag_l = job_r.left[SB-1]  ? SB'(-job_r.left)  : SB'(job_r.left);
  assign mag_r = job_r.right[SB-1] ? SB'(-job_r.right) : SB'(job_r.right);

  // one result bit per step
  assign rem_sh = {rem_r[RMW-3:0], x_r[PW-1 -: 2]};
  assign trial  = RMW'({root_r, 2'b01});
  always_comb begin
    if (rem_sh >= trial) begin
      rem_step  = rem_sh - trial;
      root_step = {root_r[RW-2:0], 1'b1};
    end else begin
      rem_step  = rem_sh;
      root_step = {root_r[RW-2:0], 1'b0};
    end
  end

  assign slot_free = !out_valid_r || out_ready;
  assign q_pop     = (state_r == B_IDLE) && !q_empty;

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    val_nxt       = val_r;
    pab_nxt       = pab_r;
    pcd_nxt       = pcd_r;
    x_nxt         = x_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    cnt_nxt       = cnt_r;
    pass_nxt      = pass_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    out_val_nxt   = out_val_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_done_nxt  = out_done_r;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          job_nxt = job_in;
          val_nxt = job_in.center;
          priority if (job_in.has_prev && job_in.interior && any_zero) begin
            val_nxt   = '0;
            state_nxt = B_EMIT1;
          end else if (job_in.has_prev && job_in.interior && !odd_neg) begin
            state_nxt = B_MUL1;
          end else if (job_in.has_prev) begin
            state_nxt = B_EMIT1;
          end else if (job_in.last_row) begin
            state_nxt = B_EMIT2;
          end else begin
            state_nxt = B_IDLE;
          end
        end
      end
      B_MUL1: begin
        pab_nxt   = RW'(mag_u) * RW'(mag_d);
        pcd_nxt   = RW'(mag_l) * RW'(mag_r);
        state_nxt = B_MUL2;
      end
      B_MUL2: begin
        x_nxt     = PW'(pab_r) * PW'(pcd_r);
        rem_nxt   = '0;
        root_nxt  = '0;
        cnt_nxt   = '0;
        pass_nxt  = 1'b0;
        state_nxt = B_ROOT;
      end
      B_ROOT: begin
        x_nxt    = x_r << 2;
        rem_nxt  = rem_step;
        root_nxt = root_step;
        cnt_nxt  = cnt_r + NW'(1);
        if (cnt_r == NW'(RW - 1)) begin
          if (!pass_r) begin
            x_nxt    = PW'(root_step);
            rem_nxt  = '0;
            root_nxt = '0;
            cnt_nxt  = '0;
            pass_nxt = 1'b1;
          end else begin
            val_nxt   = (root_step > RW'(MAXV)) ? MAXV : SB'(root_step);
            state_nxt = B_EMIT1;
          end
        end
      end
      B_EMIT1: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = val_r;
          out_row_nxt   = job_r.row - ROW_W'(1);
          out_col_nxt   = job_r.col;
          out_done_nxt  = 1'b0;
          state_nxt     = job_r.last_row ? B_EMIT2 : B_IDLE;
        end
      end
      B_EMIT2: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = job_r.down;
          out_row_nxt   = job_r.row;
          out_col_nxt   = job_r.col;
          out_done_nxt  = job_r.last_col;
          state_nxt     = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    job_r      <= job_nxt;
    val_r      <= val_nxt;
    pab_r      <= pab_nxt;
    pcd_r      <= pcd_nxt;
    x_r        <= x_nxt;
    rem_r      <= rem_nxt;
    root_r     <= root_nxt;
    cnt_r      <= cnt_nxt;
    pass_r     <= pass_nxt;
    out_val_r  <= out_val_nxt;
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
    out_done_r <= out_done_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_value      = SAMPLE_W'(out_val_r);
  assign out_row        = out_row_r;
  assign out_col        = COL_W'(out_col_r);
  assign out_frame_done = out_done_r;
endmodule
`default_nettype wire

// ----- sv/four_neighbor_geometric_mean_stencil_top.sv -----
// Flow: the front steps each sample through S_IDLE, S_RD2, S_CAP and S_PUSH; the
//   back emits a pass-through word or runs B_MUL1, B_MUL2 and two bit-serial roots.
// Overlap: the front takes a new sample only after pushing its job word, and the
//   back pops a job only in B_IDLE, so a root holds it in the shared square root unit.
// Reset: synchronous, clears position counters and sets width and height to
//   1024; the row banks are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// four_neighbor_geometric_mean_stencil_top
// Line-buffered four-neighbor geometric mean stencil over a raster stream.
// ----------------------------------------------------------------------------
`default_nettype none
module four_neighbor_geometric_mean_stencil_top #(
  parameter int MAX_WIDTH   = fngm_pkg::MAX_WIDTH_DEF,
  parameter int SAMPLE_BITS = fngm_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [fngm_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [fngm_pkg::SAMPLE_W-1:0]     out_value,
  output logic [fngm_pkg::ROW_W-1:0]               out_row,
  output logic [fngm_pkg::COL_W-1:0]               out_col,
  output logic                                     out_frame_done,
  input  wire logic                                cfg_we,
  input  wire logic [fngm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [fngm_pkg::CFG_W-1:0]          cfg_data
);
  import fngm_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int JW = 5 * SAMPLE_BITS + 16 + CW + 4;

  logic [FW_REG_W-1:0] frame_width_r, frame_width_nxt;
  logic [FH_REG_W-1:0] frame_height_r, frame_height_nxt;
  logic                q_push, q_full, q_pop, q_empty;
  logic [JW-1:0]       q_wdata, q_rdata;

  always_comb begin
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_nxt  = cfg_data[FW_REG_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_nxt = cfg_data[FH_REG_W-1:0];
        default:          frame_width_nxt  = frame_width_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
    end
  end

  fngm_front #(.MAX_WIDTH(MAX_WIDTH), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample    (in_sample),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .q_push       (q_push),
    .q_data       (q_wdata),
    .q_full       (q_full)
  );

  fngm_queue #(.WIDTH(JW), .DEPTH(2)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  fngm_back #(.MAX_WIDTH(MAX_WIDTH), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_data         (q_rdata),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_value      (out_value),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_frame_done (out_frame_done)
  );
endmodule
`default_nettype wire

// ----- sv/fngm_checker.sv -----
// ----------------------------------------------------------------------------
// fngm_checker
// Port-level checks on the stencil top, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module fngm_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_valid,
  input wire logic                                in_ready,
  input wire logic signed [fngm_pkg::SAMPLE_W-1:0] in_sample,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic signed [fngm_pkg::SAMPLE_W-1:0] out_value,
  input wire logic [fngm_pkg::ROW_W-1:0]          out_row,
  input wire logic [fngm_pkg::COL_W-1:0]          out_col,
  input wire logic                                out_frame_done,
  input wire logic                                cfg_we,
  input wire logic [fngm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input wire logic [fngm_pkg::CFG_W-1:0]          cfg_data
);
  `ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result word dropped")
  `ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_value) && $stable(out_row), "stalled result word changed")
  `ASSERT_NXT(a_front_busy, in_valid && in_ready, !in_ready, "front took two words back to back")
  `ASSERT_IMP(a_done_row, out_valid && out_frame_done, out_row != '0, "frame end on first row")
endmodule

bind four_neighbor_geometric_mean_stencil_top fngm_checker u_fngm_checker (.*);
`default_nettype wire

// ----- sim/four_neighbor_geometric_mean_stencil_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// four_neighbor_geometric_mean_stencil_top_test
// Streams raster frames through the geometric mean stencil. A local line
// buffer model predicts every word, and a checker compares the block's words
// in order. The test covers saturation, zero and negative products, register
// extremes, mid-frame resizing, idle and stall mixes, and back pressure.
// ----------------------------------------------------------------------------
module four_neighbor_geometric_mean_stencil_top_test;
  import fngm_pkg::*;

  localparam int LIMIT_CYCLES = 3000000;
  localparam int SETTLE       = 200;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic                done;
  } grid_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [SAMPLE_W-1:0] in_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] out_value;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;
  logic out_frame_done;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_FRAME_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;

  four_neighbor_geometric_mean_stencil_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_sample(in_sample),
    .out_valid(out_valid), .out_ready(out_ready), .out_value(out_value),
    .out_row(out_row), .out_col(out_col), .out_frame_done(out_frame_done),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // line buffer model state
  int unsigned width_reg, height_reg, pos_row, pos_col;
  int signed   line_bank [2*MAX_WIDTH_DEF];
  grid_word_t  pending_words [$];

  int gap_pct = 0, stall_pct = 0, hold_cycles = 0;
  int errors = 0, words_checked = 0, samples_sent = 0, frames_sent = 0;
  int cycle_count = 0;

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("four_neighbor_geometric_mean_stencil_top_test NOT OK");
      $finish;
    end
  end

  always @(posedge clk) if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;

  always @(negedge clk)
    out_ready <= (hold_cycles == 0) && ($urandom_range(99) >= stall_pct);

  task automatic report(input string what, input int got, input int exp_v);
    errors++;
    $display("mismatch %s: got %0d expected %0d (word %0d)", what, got, exp_v, words_checked);
  endtask

  always @(posedge clk) begin
    grid_word_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        report("unexpected word row", out_row, -1);
      end else begin
        e = pending_words.pop_front();
        if (out_value !== e.value) report("value", out_value, $signed(e.value));
        if (out_row !== e.row) report("row", out_row, e.row);
        if (out_col !== e.col) report("col", out_col, e.col);
        if (out_frame_done !== e.done) report("frame_done", out_frame_done, e.done);
      end
      words_checked++;
    end
  end

  function automatic longint unsigned int_root2(longint unsigned x);
    longint unsigned r = 0;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // returns 1 and sets g when the neighbor product is not negative
  function automatic bit neighbor_mean(input int signed a, b, c, d, output int signed g);
    int negs;
    longint unsigned p, root;
    negs = (a < 0) + (b < 0) + (c < 0) + (d < 0);
    g = 0;
    if (a == 0 || b == 0 || c == 0 || d == 0) return 1;
    if (negs % 2 == 1) return 0;
    p = longint'(a < 0 ? -a : a) * longint'(b < 0 ? -b : b);
    p = p * longint'(c < 0 ? -c : c) * longint'(d < 0 ? -d : d);
    root = int_root2(int_root2(p));
    g = root > 32767 ? 32767 : int'(root);
    return 1;
  endfunction

  task automatic predict_sample(input logic [SAMPLE_W-1:0] raw);
    int signed s, v, g;
    int unsigned w, h, r, c, cb, pb;
    bit last_r, last_c;
    grid_word_t wd;
    s = $signed(raw);
    w = width_reg; h = height_reg; r = pos_row; c = pos_col;
    if (w < 1) w = 1;
    if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
    if (h < 2) h = 2;
    if (c >= w) c = w - 1;
    last_r = r >= h - 1;
    last_c = c == w - 1;
    cb = (r % 2) * MAX_WIDTH_DEF;
    pb = (1 - r % 2) * MAX_WIDTH_DEF;
    if (r >= 1) begin
      v = line_bank[pb + c];
      if (!(r - 1 == 0 || r - 1 >= h - 1 || c == 0 || c >= w - 1))
        if (neighbor_mean(line_bank[cb + c], s, line_bank[pb + c - 1],
                          line_bank[pb + c + 1], g)) v = g;
      wd.value = v[15:0]; wd.row = r - 1; wd.col = c[9:0]; wd.done = 1'b0;
      pending_words.push_back(wd);
    end
    line_bank[cb + c] = s;
    if (last_r) begin
      wd.value = raw; wd.row = r; wd.col = c[9:0]; wd.done = last_c;
      pending_words.push_back(wd);
    end
    if (last_c) begin
      pos_col = 0;
      pos_row = last_r ? 0 : r + 1;
      if (last_r) frames_sent++;
    end else begin
      pos_col = c + 1;
    end
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    while ($urandom_range(99) < gap_pct) @(negedge clk);
    predict_sample(s);
    in_valid = 1'b1;
    in_sample = s;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_words.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    wait_idle();
    cfg_we = 1'b1; cfg_index = idx; cfg_data = val[CFG_W-1:0];
    if (idx == CFG_FRAME_WIDTH) width_reg = val & 32'h7FF;
    else height_reg = val & 32'hFFFF;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int k;
    k = $urandom_range(9);
    case (k)
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'h7FFF;
      3, 4, 5: return 16'($signed($urandom_range(1200)) - 600);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_frame(input int unsigned w, h);
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    repeat (w * h) send_sample(pick_sample());
  endtask

  task automatic test_directed();
    logic [SAMPLE_W-1:0] mix [12];
    mix = '{16'h0100, 16'h8000, 16'h0000, 16'h7FFF,
            16'hFF00, 16'h7FFF, 16'h0200, 16'hFFFF,
            16'h0300, 16'h7FFF, 16'h0001, 16'h8000};
    write_reg(CFG_FRAME_WIDTH, 3);
    write_reg(CFG_FRAME_HEIGHT, 3);
    repeat (9) send_sample(16'h8000);
    write_reg(CFG_FRAME_WIDTH, 4);
    foreach (mix[i]) send_sample(mix[i]);
    write_reg(CFG_FRAME_WIDTH, 0);
    write_reg(CFG_FRAME_HEIGHT, 1);
    repeat (2) send_sample(16'h1234);
  endtask

  task automatic test_register_extremes();
    write_reg(CFG_FRAME_WIDTH, 2047);
    write_reg(CFG_FRAME_HEIGHT, 65535);
    repeat (5) send_sample(pick_sample());
    write_reg(CFG_FRAME_WIDTH, 3);
    write_reg(CFG_FRAME_HEIGHT, 0);
    repeat (4) send_sample(pick_sample());
    write_reg(CFG_FRAME_WIDTH, 3);
    write_reg(CFG_FRAME_HEIGHT, 65535);
    repeat (12) send_sample(pick_sample());
    write_reg(CFG_FRAME_HEIGHT, 2);
    repeat (3) send_sample(pick_sample());
    write_reg(CFG_FRAME_WIDTH, 8);
    write_reg(CFG_FRAME_HEIGHT, 3);
    repeat (5) send_sample(pick_sample());
    write_reg(CFG_FRAME_WIDTH, 3);
    repeat (7) send_sample(pick_sample());
  endtask

  task automatic test_random_frames(input int budget, input int gap, input int stall);
    int start;
    gap_pct = gap;
    stall_pct = stall;
    start = samples_sent;
    while (samples_sent - start < budget)
      send_frame($urandom_range(1, 12), $urandom_range(2, 6));
    gap_pct = 0;
    stall_pct = 0;
  endtask

  task automatic test_back_pressure();
    wait_idle();
    hold_cycles = 400;
    send_frame(8, 6);
    wait_idle();
    send_frame(12, 5);
  endtask

  initial begin
    width_reg = FRAME_WIDTH_RST;
    height_reg = FRAME_HEIGHT_RST;
    pos_row = 0;
    pos_col = 0;
    foreach (line_bank[i]) line_bank[i] = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_register_extremes();
    test_random_frames(250, 0, 0);
    test_random_frames(250, 81, 0);
    test_random_frames(250, 0, 81);
    test_random_frames(250, 11, 11);
    test_back_pressure();
    wait_idle();
    $display("covered %0d samples in %0d frames, %0d words checked",
             samples_sent, frames_sent, words_checked);
    $display("saturation, zero and negative products, size extremes, resizing, stalls");
    if (errors == 0 && pending_words.size() == 0) begin
      $display("four_neighbor_geometric_mean_stencil_top_test OK");
    end else begin
      $display("four_neighbor_geometric_mean_stencil_top_test NOT OK");
    end
    $finish;
  end
endmodule
